/* hdl/qte_pkg.sv */
// Shared constants, CORDIC angle table and pipeline sideband types for quaternion_to_euler.
package qte_pkg;

  // internal CORDIC datapath width (magnitudes stay below 2^35)
  localparam int QTE_CW = 40;

  // reduced component width
  localparam int QTE_RB = 16;

  // 1/K in Q28
  localparam logic [27:0] QTE_INV_GAIN = 28'd163008219;

  // half turn in 32-bit turn units
  localparam logic [31:0] QTE_HALF_TURN = 32'h8000_0000;

  // atan(2^-i) in 2^32-per-turn units
  localparam logic [31:0] QTE_ATAN [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  // sideband beside the roll/yaw CORDIC
  typedef struct packed {
    logic signed [QTE_CW-1:0] a;
    logic                     clamp;
    logic                     n2z;
    logic                     zero;
    logic                     rz;
    logic                     yz;
  } side_a_t;

  // sideband beside the pitch CORDIC
  typedef struct packed {
    logic [31:0] roll_z;
    logic [31:0] yaw_z;
    logic        clamp;
    logic        n2z;
    logic        zero;
    logic        pz;
  } side_b_t;

endpackage

/* hdl/qte_cordic_step.sv */
// One registered CORDIC vectoring iteration.
module qte_cordic_step
  import qte_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [QTE_CW-1:0] x_i,
  input  logic signed [QTE_CW-1:0] y_i,
  input  logic [31:0]              z_i,
  output logic signed [QTE_CW-1:0] x_o,
  output logic signed [QTE_CW-1:0] y_o,
  output logic [31:0]              z_o
);

  logic signed [QTE_CW-1:0] xs;
  logic signed [QTE_CW-1:0] ys;
  logic                     ypos;

  assign xs   = x_i >>> STEP;
  assign ys   = y_i >>> STEP;
  assign ypos = !y_i[QTE_CW-1] && (y_i != '0);

  // rotate toward the x axis
  always_ff @(posedge clk) begin
    if (en) begin
      if (ypos) begin
        x_o <= x_i + ys;
        y_o <= y_i - xs;
        z_o <= z_i + QTE_ATAN[STEP];
      end else begin
        x_o <= x_i - ys;
        y_o <= y_i + xs;
        z_o <= z_i - QTE_ATAN[STEP];
      end
    end
  end

endmodule

/* hdl/quaternion_to_euler.sv */
// Top level: quaternion to roll/pitch/yaw converter, fully pipelined.
//
// One quaternion is taken per cycle while the skid register is empty, and
// each result passes two unrolled CORDIC chains in series, the pitch chain
// needing the magnitude out of the roll chain. A two-entry output (stage
// plus skid register) takes the beat still in flight when the sink stalls.
// Angles are binary angles with 2^ANGLE_BITS per turn; pitch_clamped marks
// gimbal lock and zero_norm an all-zero quaternion, which gives zero angles.
module quaternion_to_euler
  import qte_pkg::*;
#(
  parameter int COMPONENT_BITS = 16,
  parameter int ANGLE_BITS     = 16,
  parameter int CORDIC_STEPS   = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // comp_w, comp_x, comp_y, comp_z from bit 0 up
  input  logic [((4*COMPONENT_BITS+7)/8)*8-1:0] in_tdata,
  output logic                out_tvalid,
  input  logic                out_tready,
  // roll_angle, pitch_angle, yaw_angle from bit 0 up
  output logic [((3*ANGLE_BITS+7)/8)*8-1:0]     out_tdata,
  // pitch_clamped, zero_norm from bit 0 up
  output logic [1:0]          out_tuser
);

  localparam int CB    = COMPONENT_BITS;
  localparam int AB    = ANGLE_BITS;
  localparam int N     = CORDIC_STEPS;
  localparam int OW    = ((3*AB+7)/8)*8;
  localparam int RSH   = (CB > QTE_RB) ? CB - QTE_RB : 0;
  localparam int SH    = 32 - AB;
  localparam logic [31:0] RND = (32'd1 << SH) >> 1;
  localparam int NS    = 2*N + 7;
  localparam int ST_O  = 6 + 2*N;

  // round a 32-bit turn angle half up to AB bits
  function automatic logic [AB-1:0] to_ang(input logic [31:0] z);
    logic [31:0] s;
    s = z + RND;
    return s[31:SH];
  endfunction

  logic          adv;
  logic [NS-1:0] vld_r;
  logic          skid_v_r;

  assign adv       = !skid_v_r;
  assign in_tready = adv;

  // valid bits move with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NS-2:0], in_tvalid};
    end
  end

  // stage 0: reduce components to 16 bits
  logic signed [CB-1:0]     cw, cx, cy, cz;
  logic signed [QTE_RB-1:0] w_r, x_r, y_r, z_r;
  logic                     zero0_r;

  assign cw = $signed(in_tdata[CB-1:0]) >>> RSH;
  assign cx = $signed(in_tdata[2*CB-1:CB]) >>> RSH;
  assign cy = $signed(in_tdata[3*CB-1:2*CB]) >>> RSH;
  assign cz = $signed(in_tdata[4*CB-1:3*CB]) >>> RSH;

  always_ff @(posedge clk) begin
    if (adv) begin
      w_r     <= QTE_RB'(cw);
      x_r     <= QTE_RB'(cx);
      y_r     <= QTE_RB'(cy);
      z_r     <= QTE_RB'(cz);
      zero0_r <= (in_tdata[4*CB-1:0] == '0);
    end
  end

  // stage 1: products
  logic signed [31:0] ww_r, xx_r, yy_r, zz_r, wx_r, yz_r, wz_r, xy_r, wy_r, zx_r;
  logic               zero1_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      ww_r    <= w_r * w_r;
      xx_r    <= x_r * x_r;
      yy_r    <= y_r * y_r;
      zz_r    <= z_r * z_r;
      wx_r    <= w_r * x_r;
      yz_r    <= y_r * z_r;
      wz_r    <= w_r * z_r;
      xy_r    <= x_r * y_r;
      wy_r    <= w_r * y_r;
      zx_r    <= z_r * x_r;
      zero1_r <= zero0_r;
    end
  end

  // stage 2: numerators and squared norm
  logic signed [QTE_CW-1:0] n2_r, sr_r, cr_r, sy_r, cyw_r, a_r;
  logic                     zero2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      n2_r    <= QTE_CW'(ww_r) + QTE_CW'(xx_r) + QTE_CW'(yy_r) + QTE_CW'(zz_r);
      cr_r    <= QTE_CW'(ww_r) - QTE_CW'(xx_r) - QTE_CW'(yy_r) + QTE_CW'(zz_r);
      cyw_r   <= QTE_CW'(ww_r) + QTE_CW'(xx_r) - QTE_CW'(yy_r) - QTE_CW'(zz_r);
      sr_r    <= (QTE_CW'(wx_r) + QTE_CW'(yz_r)) <<< 1;
      sy_r    <= (QTE_CW'(wz_r) + QTE_CW'(xy_r)) <<< 1;
      a_r     <= (QTE_CW'(wy_r) - QTE_CW'(zx_r)) <<< 1;
      zero2_r <= zero1_r;
    end
  end

  // stage 3: half-turn prerotation and gimbal lock test
  logic signed [QTE_CW-1:0] ra_x [0:N];
  logic signed [QTE_CW-1:0] ra_y [0:N];
  logic [31:0]              ra_z [0:N];
  logic signed [QTE_CW-1:0] ya_x [0:N];
  logic signed [QTE_CW-1:0] ya_y [0:N];
  logic [31:0]              ya_z [0:N];
  side_a_t                  side_a_r [0:N];

  logic n2z;
  assign n2z = (n2_r == '0);

  always_ff @(posedge clk) begin
    if (adv) begin
      if (cr_r[QTE_CW-1]) begin
        ra_x[0] <= -cr_r;
        ra_y[0] <= -sr_r;
        ra_z[0] <= QTE_HALF_TURN;
      end else begin
        ra_x[0] <= cr_r;
        ra_y[0] <= sr_r;
        ra_z[0] <= '0;
      end
      if (cyw_r[QTE_CW-1]) begin
        ya_x[0] <= -cyw_r;
        ya_y[0] <= -sy_r;
        ya_z[0] <= QTE_HALF_TURN;
      end else begin
        ya_x[0] <= cyw_r;
        ya_y[0] <= sy_r;
        ya_z[0] <= '0;
      end
      side_a_r[0].a     <= a_r;
      side_a_r[0].clamp <= !n2z && ((a_r >= n2_r) || (-a_r >= n2_r));
      side_a_r[0].n2z   <= n2z;
      side_a_r[0].zero  <= zero2_r;
      side_a_r[0].rz    <= (cr_r == '0) && (sr_r == '0);
      side_a_r[0].yz    <= (cyw_r == '0) && (sy_r == '0);
    end
  end

  // roll and yaw CORDIC chains
  for (genvar k = 0; k < N; k++) begin : g_ry
    qte_cordic_step #(.STEP(k)) u_roll (
      .clk(clk), .en(adv),
      .x_i(ra_x[k]), .y_i(ra_y[k]), .z_i(ra_z[k]),
      .x_o(ra_x[k+1]), .y_o(ra_y[k+1]), .z_o(ra_z[k+1])
    );
    qte_cordic_step #(.STEP(k)) u_yaw (
      .clk(clk), .en(adv),
      .x_i(ya_x[k]), .y_i(ya_y[k]), .z_i(ya_z[k]),
      .x_o(ya_x[k+1]), .y_o(ya_y[k+1]), .z_o(ya_z[k+1])
    );
    always_ff @(posedge clk) begin
      if (adv) begin
        side_a_r[k+1] <= side_a_r[k];
      end
    end
  end

  // gain correction of the roll magnitude
  logic [62:0]              gprod;
  logic signed [QTE_CW-1:0] h_r;
  side_b_t                  side_m_r;
  logic signed [QTE_CW-1:0] am_r;

  assign gprod = ra_x[N][34:0] * QTE_INV_GAIN;

  always_ff @(posedge clk) begin
    if (adv) begin
      h_r             <= QTE_CW'(gprod[62:28]);
      am_r            <= side_a_r[N].a;
      side_m_r.roll_z <= (side_a_r[N].rz || side_a_r[N].n2z) ? '0 : ra_z[N];
      side_m_r.yaw_z  <= (side_a_r[N].yz || side_a_r[N].n2z) ? '0 : ya_z[N];
      side_m_r.clamp  <= side_a_r[N].clamp;
      side_m_r.n2z    <= side_a_r[N].n2z;
      side_m_r.zero   <= side_a_r[N].zero;
      // pitch arctangent of (0,0) gives zero
      side_m_r.pz     <= (gprod[62:28] == '0) && (side_a_r[N].a == '0);
    end
  end

  // pitch chain entry: h is never negative
  logic signed [QTE_CW-1:0] pb_x [0:N];
  logic signed [QTE_CW-1:0] pb_y [0:N];
  logic [31:0]              pb_z [0:N];
  side_b_t                  side_b_r [0:N];

  always_ff @(posedge clk) begin
    if (adv) begin
      pb_x[0]     <= h_r;
      pb_y[0]     <= am_r;
      pb_z[0]     <= '0;
      side_b_r[0] <= side_m_r;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_p
    qte_cordic_step #(.STEP(k)) u_pitch (
      .clk(clk), .en(adv),
      .x_i(pb_x[k]), .y_i(pb_y[k]), .z_i(pb_z[k]),
      .x_o(pb_x[k+1]), .y_o(pb_y[k+1]), .z_o(pb_z[k+1])
    );
    always_ff @(posedge clk) begin
      if (adv) begin
        side_b_r[k+1] <= side_b_r[k];
      end
    end
  end

  // output stage: rounding and clamp select
  localparam logic [AB-1:0] QUARTER = AB'(1) << (AB-2);

  side_b_t       sb;
  logic [AB-1:0] pitch_nxt;
  logic [AB-1:0] roll_r, pitch_r, yaw_r;
  logic [1:0]    user_r;

  assign sb = side_b_r[N];

  always_comb begin
    if (sb.n2z || (!sb.clamp && sb.pz)) begin
      pitch_nxt = '0;
    end else if (sb.clamp) begin
      pitch_nxt = QUARTER;
    end else begin
      pitch_nxt = to_ang(pb_z[N]);
    end
  end

  // clamp sign comes from a, carried beside the pitch chain
  logic asgn_r [0:N];
  always_ff @(posedge clk) begin
    if (adv) begin
      asgn_r[0] <= am_r[QTE_CW-1];
    end
  end
  for (genvar k = 0; k < N; k++) begin : g_as
    always_ff @(posedge clk) begin
      if (adv) begin
        asgn_r[k+1] <= asgn_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      roll_r  <= to_ang(sb.roll_z);
      yaw_r   <= to_ang(sb.yaw_z);
      if (sb.clamp && asgn_r[N]) begin
        pitch_r <= -QUARTER;
      end else begin
        pitch_r <= pitch_nxt;
      end
      user_r  <= {sb.zero, sb.clamp};
    end
  end

  // skid register behind the output stage
  logic [AB-1:0] sk_roll_r, sk_pitch_r, sk_yaw_r;
  logic [1:0]    sk_user_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_tready) begin
        skid_v_r <= 1'b0;
      end
    end else if (vld_r[ST_O] && !out_tready) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_v_r) begin
      sk_roll_r  <= roll_r;
      sk_pitch_r <= pitch_r;
      sk_yaw_r   <= yaw_r;
      sk_user_r  <= user_r;
    end
  end

  assign out_tvalid = skid_v_r || vld_r[ST_O];
  assign out_tdata  = skid_v_r ? OW'({sk_yaw_r, sk_pitch_r, sk_roll_r})
                               : OW'({yaw_r, pitch_r, roll_r});
  assign out_tuser  = skid_v_r ? sk_user_r : user_r;

endmodule

/* hdl/qte_checker.sv */
// Port-level checker for quaternion_to_euler and its bind.
module qte_checker #(
  parameter int ANGLE_BITS     = 16
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_tvalid,
  input logic                in_tready,
  input logic                out_tvalid,
  input logic                out_tready,
  input logic [((3*ANGLE_BITS+7)/8)*8-1:0] out_tdata,
  input logic [1:0]          out_tuser
);

  localparam int AB = ANGLE_BITS;
  localparam logic [AB-1:0] QUARTER = AB'(1) << (AB-2);
  localparam logic [AB-1:0] NQUARTER = -QUARTER;

  logic [AB-1:0] pitch;
  assign pitch = out_tdata[2*AB-1:AB];

  // stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // zero quaternion gives zero angles, no clamp
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> (out_tdata == '0) && !out_tuser[0])
    else $error("zero quaternion gave nonzero result");

  // gimbal lock pins pitch to a quarter turn
  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> (pitch == QUARTER) || (pitch == NQUARTER))
    else $error("clamped pitch not a quarter turn");

  // input backpressure only follows an output stall
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_tready) |-> $past(out_tvalid && !out_tready))
    else $error("input stalled without output stall");

endmodule

bind quaternion_to_euler qte_checker #(
  .ANGLE_BITS(ANGLE_BITS)
) u_qte_checker (
  .clk(clk), .rst_n(rst_n),
  .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata), .out_tuser(out_tuser)
);
